[hdl/atb_pkg.sv]
// ----------------------------------------------------------------------------
// atb_pkg
// Shared types and constants of the auto threshold binarizer.
// ----------------------------------------------------------------------------
package atb_pkg;

    localparam int PIX_W  = 8;
    localparam int SUM_W  = 32;
    localparam int GAIN_W = 10;
    localparam int MODE_W = 5;
    localparam int PROD_W = SUM_W + GAIN_W;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [PIX_W-1:0]  LEVEL_MAX = 8'd255;
    localparam logic [GAIN_W-1:0] GAIN_MAX  = 10'd512;
    localparam logic [SUM_W-1:0]  SUM_MAX   = 32'hFFFF_FFFF;

    localparam int MODE_EN    = 0;
    localparam int MODE_AUTO  = 1;
    localparam int MODE_BLACK = 2;
    localparam int MODE_UPPER = 3;
    localparam int MODE_LOWER = 4;

    typedef enum logic [2:0] {
        REG_MODE  = 3'd0,
        REG_UPPER = 3'd1,
        REG_LOWER = 3'd2,
        REG_GAIN  = 3'd3,
        REG_COUNT = 3'd4
    } t_reg_idx;

    typedef enum logic {
        KIND_ACC = 1'b0,
        KIND_BIN = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    typedef enum logic [3:0] {
        ST_RUN = 4'b0001,
        ST_DIV = 4'b0010,
        ST_MUL = 4'b0100,
        ST_SAT = 4'b1000
    } t_back_state;

endpackage

[hdl/atb_queue.sv]
// ----------------------------------------------------------------------------
// atb_queue
// Front part: accepts items, tags them accumulate or binarize, queues them.
// ----------------------------------------------------------------------------
module atb_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_cmd,
    input  logic [atb_pkg::PIX_W-1:0] i_pixel,
    input  logic                 i_last_pixel,
    output atb_pkg::t_head       o_head,
    input  logic                 i_pop
);
    import atb_pkg::*;

    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);

    t_entry             r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]     r_count, n_count;
    logic               push;
    logic               pop;
    t_entry             in_entry;

    assign o_stall = (r_count == (PTR_W+1)'(QDEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_count != '0);

    always_comb begin
        in_entry.kind  = i_cmd ? KIND_BIN : KIND_ACC;
        in_entry.pixel = i_pixel;
        in_entry.last  = i_last_pixel;
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_entry;
        end
    end

endmodule

[hdl/atb_div.sv]
// ----------------------------------------------------------------------------
// atb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atb_div #(
    parameter int DIVISOR_W = 25
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [atb_pkg::SUM_W-1:0]    i_dividend,
    input  logic [DIVISOR_W-1:0]         i_divisor,
    output logic                         o_done,
    output logic [atb_pkg::SUM_W-1:0]    o_quotient
);
    import atb_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIVISOR_W-1:0] r_divisor;
    logic [DIVISOR_W-1:0] r_rem;
    logic [SUM_W-1:0]     r_quo;
    logic                 r_done;
    logic [DIVISOR_W:0]   rem_sh;
    logic [DIVISOR_W:0]   rem_sub;
    logic                 q_bit;

    always_comb begin
        rem_sh  = {r_rem, r_quo[SUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_divisor};
        q_bit   = (rem_sh >= {1'b0, r_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_quo     <= i_dividend;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[hdl/atb_back.sv]
// ----------------------------------------------------------------------------
// atb_back
// Back part: sums accumulate items, derives the auto window at pass end,
// binarizes pixels and holds the result register.
// ----------------------------------------------------------------------------
module atb_back #(
    parameter int CNT_W = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  atb_pkg::t_head                i_head,
    output logic                          o_pop,
    input  logic [atb_pkg::MODE_W-1:0]    i_mode,
    input  logic [atb_pkg::PIX_W-1:0]     i_upper,
    input  logic [atb_pkg::PIX_W-1:0]     i_lower,
    input  logic [atb_pkg::GAIN_W-1:0]    i_gain,
    input  logic [CNT_W-1:0]              i_count,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [atb_pkg::PIX_W-1:0]     o_out_pixel,
    output logic                          o_applied,
    output logic                          o_out_last,
    output logic [atb_pkg::PIX_W-1:0]     o_used_low,
    output logic [atb_pkg::PIX_W-1:0]     o_used_high
);
    import atb_pkg::*;

    t_back_state        r_state, n_state;
    logic [SUM_W-1:0]   r_sum;
    logic [PIX_W-1:0]   r_auto_low, r_auto_high;
    logic [SUM_W-1:0]   r_mean;
    logic [PROD_W-1:0]  r_prod;
    logic               r_out_valid;
    logic [PIX_W-1:0]   r_out_pixel, r_out_low, r_out_high;
    logic               r_out_applied, r_out_last;

    logic [SUM_W:0]     sum_ext;
    logic [SUM_W-1:0]   sum_next;
    logic               out_free;
    logic               take_acc, take_bin;
    logic               div_start, div_done;
    logic [SUM_W-1:0]   div_quo;
    logic [GAIN_W-1:0]  gain_clamped;
    logic [PIX_W-1:0]   thr;
    logic [PIX_W-1:0]   pix, lo, hi, res;

    assign pix      = i_head.entry.pixel;
    assign sum_ext  = {1'b0, r_sum} + (SUM_W+1)'(pix);
    assign sum_next = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
    assign out_free = !r_out_valid || !i_stall;

    assign take_acc = (r_state == ST_RUN) && i_head.valid
                      && (i_head.entry.kind == KIND_ACC);
    assign take_bin = (r_state == ST_RUN) && i_head.valid
                      && (i_head.entry.kind == KIND_BIN) && out_free;
    assign o_pop    = take_acc || take_bin;
    assign div_start = take_acc && i_head.entry.last && (i_count != '0);

    assign gain_clamped = (i_gain > GAIN_MAX) ? GAIN_MAX : i_gain;
    assign thr = (r_prod[PROD_W-1:2*PIX_W] != '0) ? LEVEL_MAX : r_prod[2*PIX_W-1:PIX_W];

    atb_div #(
        .DIVISOR_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_next),
        .i_divisor  (i_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        if (i_mode[MODE_AUTO]) begin
            lo = r_auto_low;
            hi = r_auto_high;
        end else begin
            hi = i_mode[MODE_UPPER] ? i_upper : LEVEL_MAX;
            lo = i_mode[MODE_LOWER] ? i_lower : '0;
        end
        if (hi >= lo) begin
            res = (pix >= lo && pix <= hi) ? LEVEL_MAX : '0;
        end else begin
            res = (pix < hi || pix > lo) ? LEVEL_MAX : '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (div_start) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_SAT;
            ST_SAT: n_state = ST_RUN;
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_sum       <= '0;
            r_auto_low  <= '0;
            r_auto_high <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take_acc) begin
                r_sum <= i_head.entry.last ? '0 : sum_next;
                if (i_head.entry.last && (i_count == '0)) begin
                    r_auto_low  <= '0;
                    r_auto_high <= '0;
                end
            end
            if (r_state == ST_SAT) begin
                if (i_mode[MODE_BLACK]) begin
                    r_auto_low  <= thr;
                    r_auto_high <= LEVEL_MAX;
                end else begin
                    r_auto_low  <= '0;
                    r_auto_high <= thr;
                end
            end
            if (take_bin) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_done) begin
            r_mean <= div_quo;
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(r_mean) * PROD_W'(gain_clamped);
        end
        if (take_bin) begin
            r_out_last <= i_head.entry.last;
            if (i_mode[MODE_EN]) begin
                r_out_pixel   <= res;
                r_out_applied <= 1'b1;
                r_out_low     <= lo;
                r_out_high    <= hi;
            end else begin
                r_out_pixel   <= pix;
                r_out_applied <= 1'b0;
                r_out_low     <= '0;
                r_out_high    <= '0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_pixel = r_out_pixel;
    assign o_applied   = r_out_applied;
    assign o_out_last  = r_out_last;
    assign o_used_low  = r_out_low;
    assign o_used_high = r_out_high;

endmodule

[hdl/auto_threshold_binarizer_top.sv]
// ----------------------------------------------------------------------------
// auto_threshold_binarizer_top
// Binarizes 8-bit pixels against a manual or mean-derived window.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry cmd, pixel and last_pixel. An item
// with cmd=0 is summed and gives no result; at its last pixel the auto
// window is derived from the mean. An item with cmd=1 gives one result on
// o_valid / i_stall.
// Items enter a 4-entry queue; outside divider passes and output stalls the
// back end takes one per cycle, so the sustained rate is one item per clock.
// Binarize items pass the queue memory, then the output register.
// The last pixel of an accumulate pass, with a nonzero count register, starts
// a radix-2 divider: the back end holds off the queue for 32 divide steps, the
// done strobe, a multiply state and a saturate and update state.
// A receiver stall holds the output register; the queue keeps filling and
// o_stall rises once it is full.
// Synchronous reset clears the queue, the output valid, the pixel sum and
// the auto window, and loads the register reset values.
// APB: registers at byte addresses 0,4,8,12,16; pready is always high.
// ----------------------------------------------------------------------------
module auto_threshold_binarizer_top #(
    parameter int MAX_PIXELS = 16777216
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [atb_pkg::ADDR_W-1:0] paddr,
    input  logic [atb_pkg::DATA_W-1:0] pwdata,
    output logic [atb_pkg::DATA_W-1:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [atb_pkg::PIX_W-1:0] i_pixel,
    input  logic        i_last_pixel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [atb_pkg::PIX_W-1:0] o_out_pixel,
    output logic        o_applied,
    output logic        o_out_last,
    output logic [atb_pkg::PIX_W-1:0] o_used_low,
    output logic [atb_pkg::PIX_W-1:0] o_used_high
);
    import atb_pkg::*;

    localparam int CNT_W = $clog2(MAX_PIXELS + 1);

    logic [MODE_W-1:0] r_mode;
    logic [PIX_W-1:0]  r_upper;
    logic [PIX_W-1:0]  r_lower;
    logic [GAIN_W-1:0] r_gain;
    logic [CNT_W-1:0]  r_count;
    logic              wr_en;
    t_reg_idx          reg_idx;
    t_head             head;
    logic              pop;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_upper <= LEVEL_MAX;
            r_lower <= '0;
            r_gain  <= GAIN_W'(256);
            r_count <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODE:  r_mode  <= pwdata[MODE_W-1:0];
                REG_UPPER: r_upper <= pwdata[PIX_W-1:0];
                REG_LOWER: r_lower <= pwdata[PIX_W-1:0];
                REG_GAIN:  r_gain  <= pwdata[GAIN_W-1:0];
                REG_COUNT: r_count <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODE:  prdata = DATA_W'(r_mode);
            REG_UPPER: prdata = DATA_W'(r_upper);
            REG_LOWER: prdata = DATA_W'(r_lower);
            REG_GAIN:  prdata = DATA_W'(r_gain);
            REG_COUNT: prdata = DATA_W'(r_count);
            default:   prdata = '0;
        endcase
    end

    atb_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_pixel      (i_pixel),
        .i_last_pixel (i_last_pixel),
        .o_head       (head),
        .i_pop        (pop)
    );

    atb_back #(
        .CNT_W (CNT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_mode      (r_mode),
        .i_upper     (r_upper),
        .i_lower     (r_lower),
        .i_gain      (r_gain),
        .i_count     (r_count),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_pixel (o_out_pixel),
        .o_applied   (o_applied),
        .o_out_last  (o_out_last),
        .o_used_low  (o_used_low),
        .o_used_high (o_used_high)
    );

endmodule
